### src/upx_pkg.sv
package upx_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_LOW_WIDTH  = 1024;
  localparam int unsigned MAX_LOW_HEIGHT = 1024;
  localparam int unsigned COL_W          = $clog2(MAX_LOW_WIDTH);
  localparam int unsigned ROW_W          = $clog2(MAX_LOW_HEIGHT);

  // Fixed field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 1;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LOW_WIDTH  = 1'b0,
    REG_LOW_HEIGHT = 1'b1
  } cfg_reg_e;

  // Output position relative to the source pixel along one axis:
  // one before (odd), the even copy spot, or the frame's last line/column
  typedef enum logic [1:0] {
    POS_PREV   = 2'd0,
    POS_EVEN   = 2'd1,
    POS_BORDER = 2'd2
  } pos_e;

  // One classified source pixel with its neighbors
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] upleft;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             col_last;
    logic             row_last;
  } job_t;

endpackage

### src/upx_front.sv
module upx_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [upx_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [upx_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          push_i,
  input  logic [upx_pkg::PIX_W-1:0]     pixel_i,
  output logic                          full_o,
  output upx_pkg::job_t                 job_o,
  output logic                          job_valid_o,
  input  logic                          job_ready_i
);

  // Geometry, stored as size minus one
  logic [upx_pkg::COL_W-1:0] w_m1_q, w_m1_d;
  logic [upx_pkg::ROW_W-1:0] h_m1_q, h_m1_d;

  // Raster position of the next accepted pixel
  logic [upx_pkg::COL_W-1:0] col_q, col_d;
  logic [upx_pkg::ROW_W-1:0] row_q, row_d;

  // Lookup stage
  logic                      s1_valid_q, s1_valid_d;
  logic [upx_pkg::PIX_W-1:0] s1_pix_q;
  logic [upx_pkg::COL_W-1:0] s1_col_q;
  logic [upx_pkg::ROW_W-1:0] s1_row_q;
  logic                      s1_col_last_q;
  logic                      s1_row_last_q;
  logic [upx_pkg::PIX_W-1:0] up_q;

  // Neighbor registers
  logic [upx_pkg::PIX_W-1:0] left_q, left_d;
  logic [upx_pkg::PIX_W-1:0] upleft_q, upleft_d;

  // Previous-row line store
  logic [upx_pkg::PIX_W-1:0] line_mem [upx_pkg::MAX_LOW_WIDTH];

  logic accept;
  logic handoff;
  logic col_last;
  logic row_last;

  assign full_o   = s1_valid_q && !job_ready_i;
  assign accept   = push_i && !full_o;
  assign handoff  = s1_valid_q && job_ready_i;
  assign col_last = (col_q == w_m1_q);
  assign row_last = (row_q == h_m1_q);

  // Geometry writes, clamped to 1..max
  always_comb begin
    w_m1_d = w_m1_q;
    h_m1_d = h_m1_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        upx_pkg::REG_LOW_WIDTH: begin
          if (cfg_wdata_i == '0) begin
            w_m1_d = '0;
          end else if (cfg_wdata_i > upx_pkg::CFG_W'(upx_pkg::MAX_LOW_WIDTH)) begin
            w_m1_d = upx_pkg::COL_W'(upx_pkg::MAX_LOW_WIDTH - 1);
          end else begin
            w_m1_d = upx_pkg::COL_W'(cfg_wdata_i - upx_pkg::CFG_W'(1));
          end
        end
        upx_pkg::REG_LOW_HEIGHT: begin
          if (cfg_wdata_i == '0) begin
            h_m1_d = '0;
          end else if (cfg_wdata_i > upx_pkg::CFG_W'(upx_pkg::MAX_LOW_HEIGHT)) begin
            h_m1_d = upx_pkg::ROW_W'(upx_pkg::MAX_LOW_HEIGHT - 1);
          end else begin
            h_m1_d = upx_pkg::ROW_W'(cfg_wdata_i - upx_pkg::CFG_W'(1));
          end
        end
        default: ;
      endcase
    end
  end

  // Raster counters; a geometry write restarts the frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + upx_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + upx_pkg::COL_W'(1);
      end
    end
  end

  // Lookup stage holds while the queue is full
  assign s1_valid_d = accept || (s1_valid_q && !job_ready_i);

  // Neighbors shift on handoff, clear at row end
  always_comb begin
    left_d   = left_q;
    upleft_d = upleft_q;
    if (cfg_we_i) begin
      left_d   = '0;
      upleft_d = '0;
    end else if (handoff) begin
      left_d   = s1_col_last_q ? '0 : s1_pix_q;
      upleft_d = s1_col_last_q ? '0 : up_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q     <= upx_pkg::COL_W'(640 - 1);
      h_m1_q     <= upx_pkg::ROW_W'(480 - 1);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
      upleft_q   <= '0;
    end else begin
      w_m1_q     <= w_m1_d;
      h_m1_q     <= h_m1_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      left_q     <= left_d;
      upleft_q   <= upleft_d;
    end
  end

  // Payload of the lookup stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= pixel_i;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_col_last_q <= col_last;
      s1_row_last_q <= row_last;
    end
  end

  // Line store: read old value, write new one, same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= pixel_i;
      up_q            <= line_mem[col_q];
    end
  end

  assign job_valid_o     = s1_valid_q;
  assign job_o.pix       = s1_pix_q;
  assign job_o.up        = up_q;
  assign job_o.left      = left_q;
  assign job_o.upleft    = upleft_q;
  assign job_o.col       = s1_col_q;
  assign job_o.row       = s1_row_q;
  assign job_o.col_last  = s1_col_last_q;
  assign job_o.row_last  = s1_row_last_q;

endmodule

### src/upx_job_fifo.sv
module upx_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upx_pkg::job_t wr_data_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output upx_pkg::job_t rd_data_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  upx_pkg::job_t     slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]    count_q, count_d;
  logic              do_wr, do_rd;

  assign wr_ready_o = (count_q != (PTR_W+1)'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = slot_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + (PTR_W+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/upx_back.sv
module upx_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  upx_pkg::job_t               job_i,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [upx_pkg::COORD_W-1:0] out_x_o,
  output logic [upx_pkg::COORD_W-1:0] out_y_o,
  output logic [upx_pkg::PIX_W-1:0]   out_value_o,
  output logic                        run_last_o,
  output logic                        frame_done_o
);

  function automatic upx_pkg::pos_e next_pos(upx_pkg::pos_e p);
    upx_pkg::pos_e n;
    unique case (p)
      upx_pkg::POS_PREV: n = upx_pkg::POS_EVEN;
      upx_pkg::POS_EVEN: n = upx_pkg::POS_BORDER;
      default:           n = upx_pkg::POS_BORDER;
    endcase
    return n;
  endfunction

  upx_pkg::job_t job_q;
  logic          active_q, active_d;
  upx_pkg::pos_e xk_q, xk_d, yk_q, yk_d;
  upx_pkg::pos_e x_end, y_end, x_start, y_start, x_first_new, y_first_new;

  logic                        out_valid_q, out_valid_d;
  logic [upx_pkg::COORD_W-1:0] x_cur, y_cur;
  logic [upx_pkg::PIX_W-1:0]   val_cur;
  logic [upx_pkg::PIX_W:0]     sum_vert, sum_horz;
  logic [upx_pkg::PIX_W+1:0]   sum_quad;
  logic                        adv, last, load;

  // Walk bounds of the current pixel
  assign x_start     = (job_q.col != '0) ? upx_pkg::POS_PREV : upx_pkg::POS_EVEN;
  assign x_end       = job_q.col_last ? upx_pkg::POS_BORDER : upx_pkg::POS_EVEN;
  assign y_end       = job_q.row_last ? upx_pkg::POS_BORDER : upx_pkg::POS_EVEN;
  assign x_first_new = (job_i.col != '0) ? upx_pkg::POS_PREV : upx_pkg::POS_EVEN;
  assign y_first_new = (job_i.row != '0) ? upx_pkg::POS_PREV : upx_pkg::POS_EVEN;
  assign y_start     = y_first_new;

  assign adv         = active_q && (!out_valid_q || pop_i);
  assign last        = (xk_q == x_end) && (yk_q == y_end);
  assign load        = job_valid_i && (!active_q || (adv && last));
  assign job_ready_o = load;

  // Walk rows outer, columns inner
  always_comb begin
    active_d = active_q;
    xk_d     = xk_q;
    yk_d     = yk_q;
    if (load) begin
      active_d = 1'b1;
      xk_d     = x_first_new;
      yk_d     = y_start;
    end else if (adv && last) begin
      active_d = 1'b0;
    end else if (adv) begin
      if (xk_q == x_end) begin
        xk_d = x_start;
        yk_d = next_pos(yk_q);
      end else begin
        xk_d = next_pos(xk_q);
      end
    end
  end

  // Coordinates: 2c-1, 2c or 2c+1
  always_comb begin
    case (xk_q)
      upx_pkg::POS_PREV:   x_cur = upx_pkg::COORD_W'({job_q.col, 1'b0}) - upx_pkg::COORD_W'(1);
      upx_pkg::POS_EVEN:   x_cur = upx_pkg::COORD_W'({job_q.col, 1'b0});
      default:             x_cur = upx_pkg::COORD_W'({job_q.col, 1'b1});
    endcase
    case (yk_q)
      upx_pkg::POS_PREV:   y_cur = upx_pkg::COORD_W'({job_q.row, 1'b0}) - upx_pkg::COORD_W'(1);
      upx_pkg::POS_EVEN:   y_cur = upx_pkg::COORD_W'({job_q.row, 1'b0});
      default:             y_cur = upx_pkg::COORD_W'({job_q.row, 1'b1});
    endcase
  end

  // Rounded means
  assign sum_vert = {1'b0, job_q.up} + {1'b0, job_q.pix} + (upx_pkg::PIX_W+1)'(1);
  assign sum_horz = {1'b0, job_q.left} + {1'b0, job_q.pix} + (upx_pkg::PIX_W+1)'(1);
  assign sum_quad = {2'b0, job_q.upleft} + {2'b0, job_q.up} + {2'b0, job_q.left}
                  + {2'b0, job_q.pix} + (upx_pkg::PIX_W+2)'(2);

  always_comb begin
    if ((xk_q == upx_pkg::POS_BORDER) || (yk_q == upx_pkg::POS_BORDER)) begin
      val_cur = '0;
    end else if ((xk_q == upx_pkg::POS_EVEN) && (yk_q == upx_pkg::POS_EVEN)) begin
      val_cur = job_q.pix;
    end else if (xk_q == upx_pkg::POS_EVEN) begin
      val_cur = sum_vert[upx_pkg::PIX_W:1];
    end else if (yk_q == upx_pkg::POS_EVEN) begin
      val_cur = sum_horz[upx_pkg::PIX_W:1];
    end else begin
      val_cur = sum_quad[upx_pkg::PIX_W+1:2];
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      xk_q        <= upx_pkg::POS_EVEN;
      yk_q        <= upx_pkg::POS_EVEN;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      xk_q        <= xk_d;
      yk_q        <= yk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_x_o      <= x_cur;
      out_y_o      <= y_cur;
      out_value_o  <= val_cur;
      run_last_o   <= last;
      frame_done_o <= last && job_q.col_last && job_q.row_last;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

### src/bilinear_upsample_2x.sv
// 2x bilinear upscaler for 8-bit gray pixels. Source pixels enter in raster order
// through push/full; every pixel releases the output pixels whose neighbors are
// now known (one to nine, four in the frame interior), each beat tagged with its
// coordinates, run_last on the last beat of that pixel and frame_done on the last
// beat of the frame. Results leave the back end's output register one beat per
// cycle while pop is held; the back end takes the next pixel as it emits the last
// beat of the current one. The previous row sits in a 1024-entry line store with
// one registered read per pixel; a four-entry queue separates pixel intake from
// result generation. Geometry is written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write it only while idle; the block does not enforce this. 0 acts
// as 1 and values above 1024 act as 1024, and any write restarts the frame. The
// line store is not cleared: the first row's upper neighbors are undefined, but
// they only feed results that are never emitted.
module bilinear_upsample_2x (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [upx_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [upx_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [upx_pkg::PIX_W-1:0]   pixel_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [upx_pkg::COORD_W-1:0] out_x_o,
  output logic [upx_pkg::COORD_W-1:0] out_y_o,
  output logic [upx_pkg::PIX_W-1:0]   out_value_o,
  output logic                        run_last_o,
  output logic                        frame_done_o
);

  upx_pkg::job_t front_job, back_job;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  // Intake, counters and line store
  upx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .pixel_i     (pixel_i),
    .full_o      (full),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  // Decoupling queue
  upx_job_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_job),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (back_job),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  // Result generation
  upx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (back_job),
    .job_valid_i  (back_valid),
    .job_ready_o  (back_ready),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_value_o  (out_value_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

endmodule
